>>> design/spnp_pkg.sv
// Shared types and constants for the source/sink path node pruner.
// No dependencies; imported by st_path_node_pruner and spnp_chk.
package spnp_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);

	// Request codes
	localparam logic [1:0] REQ_EDGE  = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_RUN   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_WR,
		ST_PICK,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef logic [MAX_NODES-1:0] node_set_t;

endpackage

>>> design/st_path_node_pruner.sv
// Source/sink reachability pruner over a directed bit-matrix graph.
// Depends on spnp_pkg and spnp_ram (row and column stores of the matrix).
//
// Usage: a request word is taken at a clock edge where start is high and
// busy is low. req_type selects an edge write (from_node, to_node,
// edge_present), a clear of the whole matrix, or a run. Code 3 is taken and
// ignored. cfg_we/cfg_wdata write active_nodes; the user must do so only
// while the block is idle, as the block itself does not enforce this.
//
// Operation: a clear takes effect in the accepting cycle and leaves busy
// low. An edge write holds busy through ST_EDGE_WR (read-modify-write of
// one row and one column). A run walks forward from node 0 over the row
// store, then backward from the sink over the column store; each walk step
// is a RAM read (ST_PICK) plus an update (ST_UPDATE), at most n steps per
// walk, and each walk ends with a turnaround in ST_PICK. Then n results
// follow on consecutive cycles, each marked by strobe for one cycle; n is
// the clamped node count. The receiver cannot stall: every result is taken
// in its strobe cycle. Reset empties the matrix (per-entry valid bits),
// sets active_nodes to 64 and returns the sequencer to idle.
module st_path_node_pruner
	import spnp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	input  logic              edge_present,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	output logic              strobe,
	output logic [NODE_W-1:0] node_id,
	output logic              on_path,
	output logic [NODE_W-1:0] new_id,
	output logic              last
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  active_nodes_q;
	node_set_t         rows_valid_q, cols_valid_q;
	logic              back_q;
	logic              strobe_q;

	logic [NODE_W-1:0] from_q, to_q;
	logic              present_q;
	node_set_t         reached_q, pending_q, path_q;
	logic [CNT_W-1:0]  steps_q;
	logic [NODE_W-1:0] pick_q, idx_q, dropped_q;
	logic [NODE_W-1:0] node_id_q, new_id_q;
	logic              on_path_q, last_q;

	logic [CNT_W-1:0]  n_cnt;
	logic [NODE_W-1:0] sink;
	node_set_t         node_mask;
	logic [NODE_W-1:0] pick;
	logic              accept, walk_more;

	logic [NODE_W-1:0] rows_raddr, cols_raddr;
	node_set_t         rows_rdata, cols_rdata;
	logic              ram_we;
	node_set_t         rows_wdata, cols_wdata;
	node_set_t         rows_eff, cols_eff, tbl, fresh;

	// Clamp the node count and derive sink and active mask
	always_comb begin
		if (active_nodes_q < CNT_W'(2)) begin
			n_cnt = CNT_W'(2);
		end else if (active_nodes_q > CNT_W'(MAX_NODES)) begin
			n_cnt = CNT_W'(MAX_NODES);
		end else begin
			n_cnt = active_nodes_q;
		end
		sink = NODE_W'(n_cnt - CNT_W'(1));
		for (int k = 0; k < MAX_NODES; k++) begin
			node_mask[k] = (CNT_W'(k) < n_cnt);
		end
	end

	// Lowest pending node
	always_comb begin
		pick = '0;
		for (int k = MAX_NODES - 1; k >= 0; k--) begin
			if (pending_q[k]) begin
				pick = NODE_W'(k);
			end
		end
	end

	assign accept    = start && (state_q == ST_IDLE);
	assign walk_more = (steps_q < n_cnt) && (pending_q != '0);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_EDGE: state_d = ST_EDGE_WR;
						REQ_RUN:  state_d = ST_PICK;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_EDGE_WR: state_d = ST_IDLE;
			ST_PICK: begin
				if (walk_more) begin
					state_d = ST_UPDATE;
				end else if (back_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_UPDATE: state_d = ST_PICK;
			ST_EMIT: begin
				if (idx_q == sink) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Read addresses: request fields at accept, picked node during a walk
	assign rows_raddr = (state_q == ST_IDLE) ? from_node : pick;
	assign cols_raddr = (state_q == ST_IDLE) ? to_node   : pick;

	// Read data of entries never written since reset or clear reads as zero
	always_comb begin
		if (state_q == ST_EDGE_WR) begin
			rows_eff = rows_valid_q[from_q] ? rows_rdata : '0;
			cols_eff = cols_valid_q[to_q]   ? cols_rdata : '0;
		end else begin
			rows_eff = rows_valid_q[pick_q] ? rows_rdata : '0;
			cols_eff = cols_valid_q[pick_q] ? cols_rdata : '0;
		end
		rows_wdata         = rows_eff;
		rows_wdata[to_q]   = present_q;
		cols_wdata         = cols_eff;
		cols_wdata[from_q] = present_q;
		tbl   = back_q ? cols_eff : rows_eff;
		fresh = tbl & node_mask & ~reached_q;
	end

	assign ram_we = (state_q == ST_EDGE_WR);

	spnp_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (from_q),
		.wdata (rows_wdata),
		.raddr (rows_raddr),
		.rdata (rows_rdata)
	);

	spnp_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_cols (
		.clk   (clk),
		.we    (ram_we),
		.waddr (to_q),
		.wdata (cols_wdata),
		.raddr (cols_raddr),
		.rdata (cols_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control: node count, valid bits, walk direction, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_nodes_q <= CNT_W'(MAX_NODES);
			rows_valid_q   <= '0;
			cols_valid_q   <= '0;
			back_q         <= 1'b0;
			strobe_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_nodes_q <= cfg_wdata;
			end
			if (accept && req_type == REQ_CLEAR) begin
				rows_valid_q <= '0;
				cols_valid_q <= '0;
			end else if (state_q == ST_EDGE_WR) begin
				rows_valid_q[from_q] <= 1'b1;
				cols_valid_q[to_q]   <= 1'b1;
			end
			if (accept && req_type == REQ_RUN) begin
				back_q <= 1'b0;
			end else if (state_q == ST_PICK && !walk_more) begin
				back_q <= 1'b1;
			end
			strobe_q <= (state_q == ST_EMIT);
		end
	end

	// Datapath: request capture, walk sets, result words
	always_ff @(posedge clk) begin
		if (accept) begin
			from_q    <= from_node;
			to_q      <= to_node;
			present_q <= edge_present;
			// seed the forward walk at the source
			reached_q <= node_set_t'(1);
			pending_q <= node_set_t'(1);
			steps_q   <= '0;
		end
		if (state_q == ST_PICK) begin
			if (walk_more) begin
				pick_q            <= pick;
				pending_q[pick]   <= 1'b0;
			end else if (!back_q) begin
				// forward done: keep result, seed backward walk at the sink
				path_q    <= reached_q;
				reached_q <= node_set_t'(1) << sink;
				pending_q <= node_set_t'(1) << sink;
				steps_q   <= '0;
			end else begin
				path_q    <= path_q & reached_q;
				idx_q     <= '0;
				dropped_q <= '0;
			end
		end
		if (state_q == ST_UPDATE) begin
			reached_q <= reached_q | fresh;
			pending_q <= pending_q | fresh;
			steps_q   <= steps_q + CNT_W'(1);
		end
		if (state_q == ST_EMIT) begin
			node_id_q <= idx_q;
			on_path_q <= path_q[idx_q];
			new_id_q  <= idx_q - dropped_q;
			last_q    <= (idx_q == sink);
			dropped_q <= dropped_q + NODE_W'(!path_q[idx_q]);
			idx_q     <= idx_q + NODE_W'(1);
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign strobe  = strobe_q;
	assign node_id = node_id_q;
	assign on_path = on_path_q;
	assign new_id  = new_id_q;
	assign last    = strobe_q & last_q;

endmodule

>>> design/spnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spnp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/spnp_chk.sv
// Port-level checks for st_path_node_pruner, bound to the top level.
// Depends on spnp_pkg for request codes and widths.
module spnp_chk
	import spnp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        req_type,
	input logic              strobe,
	input logic [NODE_W-1:0] node_id,
	input logic              last
);

	// A result word marked last only comes with the strobe
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

	// Result words of one run are contiguous
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside result burst");

	// Node ids advance by one through a burst
	a_ids: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> node_id == NODE_W'($past(node_id) + NODE_W'(1)))
		else $error("node id out of order");

	// A burst ends after its last word
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("strobe after last word");

	// An accepted run occupies the block
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type == REQ_RUN |=> busy)
		else $error("run accepted but block not busy");

endmodule

bind st_path_node_pruner spnp_chk u_spnp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req_type (req_type),
	.strobe   (strobe),
	.node_id  (node_id),
	.last     (last)
);
